@@ design/ctb_pkg.sv @@
`default_nettype none
package ctb_pkg;

  localparam int NUM_TIMERS  = 4;
  localparam int DATA_W      = 16;
  localparam int PRESCALE_W  = 10;
  localparam int IRQ_W       = 4;
  localparam int OFFSET_W    = 3;

  // control halfword layout
  localparam int CTL_DIV_LSB = 0;
  localparam int CTL_CASCADE = 2;
  localparam int CTL_IRQ     = 6;
  localparam int CTL_ENABLE  = 7;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    DIV_1    = 2'd0,
    DIV_64   = 2'd1,
    DIV_256  = 2'd2,
    DIV_1024 = 2'd3
  } div_sel_t;

  // command from the decode logic to one timer channel
  typedef struct packed {
    logic                  tick;
    logic                  wr_reload;
    logic                  wr_ctrl;
    logic [DATA_W-1:0]     data;
    logic [PRESCALE_W-1:0] prescale;
  } ctb_cmd_t;

  // readback from one timer channel
  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] ctrl;
  } ctb_stat_t;

  // low prescale bits that must be zero for a count to happen
  function automatic logic [PRESCALE_W-1:0] div_mask(input div_sel_t sel);
    logic [PRESCALE_W-1:0] m;
    unique case (sel)
      DIV_1:    m = PRESCALE_W'(10'h000);
      DIV_64:   m = PRESCALE_W'(10'h03F);
      DIV_256:  m = PRESCALE_W'(10'h0FF);
      DIV_1024: m = PRESCALE_W'(10'h3FF);
      default:  m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] ctrl_word(input div_sel_t sel, input logic casc,
                                                  input logic irq_en, input logic run);
    logic [DATA_W-1:0] w;
    w = '0;
    w[CTL_DIV_LSB +: 2] = sel;
    w[CTL_CASCADE]      = casc;
    w[CTL_IRQ]          = irq_en;
    w[CTL_ENABLE]       = run;
    return w;
  endfunction

endpackage
`default_nettype wire

@@ design/ctb_timer.sv @@
`default_nettype none
module ctb_timer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctb_pkg::ctb_cmd_t cmd,
  input  wire logic              below_ovf,
  output logic                   ovf,
  output logic                   irq,
  output ctb_pkg::ctb_stat_t     stat
);

  logic [ctb_pkg::DATA_W-1:0] count;
  logic [ctb_pkg::DATA_W-1:0] count_next;
  logic [ctb_pkg::DATA_W-1:0] reload;
  ctb_pkg::div_sel_t          div_sel;
  logic                       cascade;
  logic                       irq_en;
  logic                       running;
  logic                       div_hit;
  logic                       counts;
  logic                       start;

  // decide whether this channel counts in the current tick
  assign div_hit = (cmd.prescale & ctb_pkg::div_mask(div_sel)) == '0;
  assign counts  = cmd.tick && running && (cascade ? below_ovf : div_hit);
  assign ovf     = counts && (count == {ctb_pkg::DATA_W{1'b1}});
  assign irq     = ovf && irq_en;
  assign start   = cmd.wr_ctrl && !running && cmd.data[ctb_pkg::CTL_ENABLE];

  // advance, reload on overflow, or load on start
  always_comb begin
    count_next = count;
    if (ovf) begin
      count_next = reload;
    end else if (counts) begin
      count_next = count + ctb_pkg::DATA_W'(1);
    end else if (start) begin
      count_next = reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      reload  <= '0;
      div_sel <= ctb_pkg::DIV_1;
      cascade <= 1'b0;
      irq_en  <= 1'b0;
      running <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.wr_reload) begin
        reload <= cmd.data;
      end
      if (cmd.wr_ctrl) begin
        div_sel <= ctb_pkg::div_sel_t'(cmd.data[ctb_pkg::CTL_DIV_LSB +: 2]);
        cascade <= cmd.data[ctb_pkg::CTL_CASCADE];
        irq_en  <= cmd.data[ctb_pkg::CTL_IRQ];
        running <= cmd.data[ctb_pkg::CTL_ENABLE];
      end
    end
  end

  assign stat.count = count;
  assign stat.ctrl  = ctb_pkg::ctrl_word(div_sel, cascade, irq_en, running);

  // overflow always lands on the reload value
  a_ovf_reload: assert property (@(posedge clk) disable iff (rst)
    ovf && !cmd.wr_reload |=> count == $past(reload))
    else $error("timer did not reload after overflow");

  // only ticks and starts move the count
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.tick && !start |=> count == $past(count))
    else $error("count moved without tick or start");

  // a stopped timer never overflows
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    !running |-> !ovf)
    else $error("stopped timer overflowed");

endmodule
`default_nettype wire

@@ design/cascaded_timer_bank.sv @@
`default_nettype none
// Bank of 16-bit up-counting timers behind a halfword register window. Each
// transaction is a tick, a register read or a register write, and gives exactly
// one result transaction. One transaction is taken every clock cycle while in_stall
// is low; each passes an input register and then a result register on its way
// to the output. A stalled result register holds the input register, and input is
// refused only while both are full. The cycle time is set by the overflow flags
// rippling through the four channels (one all-ones compare each) and the count
// muxes.
module cascaded_timer_bank (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      action,
  input  wire logic [ctb_pkg::OFFSET_W-1:0]    reg_offset,
  input  wire logic [ctb_pkg::DATA_W-1:0]      write_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ctb_pkg::DATA_W-1:0]           read_data,
  output logic [ctb_pkg::IRQ_W-1:0]            irq_pulse
);

  localparam int N = ctb_pkg::NUM_TIMERS;

  logic                             in_q_valid;
  ctb_pkg::action_t                 act_q;
  logic [ctb_pkg::OFFSET_W-1:0]     offset_q;
  logic [ctb_pkg::DATA_W-1:0]       data_q;
  logic                             advance;
  logic                             fire;
  logic [ctb_pkg::PRESCALE_W-1:0]   prescale;
  logic [ctb_pkg::PRESCALE_W-1:0]   prescale_next;
  logic                             is_tick;
  logic                             is_read;
  logic                             is_write;
  logic [ctb_pkg::OFFSET_W-1:0]     tsel;
  ctb_pkg::ctb_cmd_t                cmd       [N];
  ctb_pkg::ctb_stat_t               stat      [N];
  logic [N-1:0]                     ovf;
  logic [N-1:0]                     irq;
  logic [N-1:0]                     below;
  logic [ctb_pkg::DATA_W-1:0]       rd_next;
  logic [ctb_pkg::IRQ_W-1:0]        irq_next;

  // hold the input register while the result register cannot drain
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign fire     = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      act_q    <= ctb_pkg::action_t'(action);
      offset_q <= reg_offset;
      data_q   <= write_data;
    end
  end

  // decode the action
  always_comb begin
    is_tick  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (act_q)
      ctb_pkg::ACT_TICK:  is_tick  = fire;
      ctb_pkg::ACT_READ:  is_read  = fire;
      ctb_pkg::ACT_WRITE: is_write = fire;
      default: ;
    endcase
  end

  // advance the free-running prescaler on each tick
  assign prescale_next = prescale + ctb_pkg::PRESCALE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= '0;
    end else if (is_tick) begin
      prescale <= prescale_next;
    end
  end

  assign tsel = ctb_pkg::OFFSET_W'(offset_q >> 1);

  // timer channels, chained through their overflow flags
  for (genvar i = 0; i < N; i++) begin : g_timer
    if (i == 0) begin : g_first
      assign below[i] = 1'b0;
    end else begin : g_rest
      assign below[i] = ovf[i-1];
    end

    assign cmd[i].tick      = is_tick;
    assign cmd[i].wr_reload = is_write && (tsel == ctb_pkg::OFFSET_W'(i)) && !offset_q[0];
    assign cmd[i].wr_ctrl   = is_write && (tsel == ctb_pkg::OFFSET_W'(i)) && offset_q[0];
    assign cmd[i].data      = data_q;
    assign cmd[i].prescale  = prescale_next;

    ctb_timer u_timer (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd[i]),
      .below_ovf (below[i]),
      .ovf       (ovf[i]),
      .irq       (irq[i]),
      .stat      (stat[i])
    );
  end

  // only the lowest interrupt lines reach the output
  for (genvar b = 0; b < ctb_pkg::IRQ_W; b++) begin : g_irq
    if (b < N) begin : g_live
      assign irq_next[b] = irq[b];
    end else begin : g_zero
      assign irq_next[b] = 1'b0;
    end
  end

  // select the readback halfword
  always_comb begin
    rd_next = '0;
    if (is_read) begin
      for (int i = 0; i < N; i++) begin
        if (tsel == ctb_pkg::OFFSET_W'(i)) begin
          rd_next = offset_q[0] ? stat[i].ctrl : stat[i].count;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data <= rd_next;
      irq_pulse <= irq_next;
    end
  end

  // an empty result register never stalls the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with result register empty");

  // a transaction carries either read data or interrupts, never both
  a_rd_irq_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && (irq_pulse != '0) |-> read_data == '0)
    else $error("read data and interrupt pulse together");

  // prescaler moves by exactly one per tick and holds otherwise
  a_prescale_step: assert property (@(posedge clk) disable iff (rst)
    is_tick |=> prescale == $past(prescale_next))
    else $error("prescaler did not advance on tick");

  a_prescale_hold: assert property (@(posedge clk) disable iff (rst)
    !is_tick |=> $stable(prescale))
    else $error("prescaler moved without tick");

endmodule
`default_nettype wire

@@ test/cascaded_timer_bank_tb.sv @@
`timescale 1ns / 1ps
module cascaded_timer_bank_tb;
  import ctb_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int QUIET_ITEMS  = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_ROWS     = 25;
  // action code with no meaning: the block must answer zero and change nothing
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_pulse;
  } timer_result_t;

  typedef struct packed {
    logic [1:0]          act;
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]   data;
    logic                known;
    timer_result_t       result;
  } directed_row_t;

  // directed transactions; rows marked known carry the answer typed in
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ACT_READ,   3'd0, 16'h0000, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_READ,   3'd7, 16'h0000, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_TICK,   3'd0, 16'h0000, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_UNUSED, 3'd5, 16'hFFFF, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd0, 16'hFFFF, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd1, 16'hFFFF, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_READ,   3'd1, 16'h0000, 1'b1, '{16'h00C7, 4'h0}},
    '{ACT_READ,   3'd0, 16'h0000, 1'b1, '{16'hFFFF, 4'h0}},
    '{ACT_TICK,   3'd0, 16'h0000, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd1, 16'h00C0, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_TICK,   3'd0, 16'h0000, 1'b0, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd2, 16'hFFFF, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd3, 16'h00C4, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_TICK,   3'd0, 16'h0000, 1'b0, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd6, 16'hFFFF, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd7, 16'h00C4, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd5, 16'h0083, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_TICK,   3'd0, 16'h0000, 1'b0, '{16'h0000, 4'h0}},
    '{ACT_READ,   3'd5, 16'h0000, 1'b1, '{16'h0083, 4'h0}},
    '{ACT_WRITE,  3'd1, 16'h0000, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_TICK,   3'd0, 16'h0000, 1'b0, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd0, 16'h1234, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_READ,   3'd0, 16'h0000, 1'b0, '{16'h0000, 4'h0}},
    '{ACT_WRITE,  3'd3, 16'hFF38, 1'b1, '{16'h0000, 4'h0}},
    '{ACT_READ,   3'd3, 16'h0000, 1'b1, '{16'h0000, 4'h0}}
  };

  logic                clk;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [1:0]          action     = ACT_TICK;
  logic [OFFSET_W-1:0] reg_offset = '0;
  logic [DATA_W-1:0]   write_data = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [DATA_W-1:0]   read_data;
  logic [IRQ_W-1:0]    irq_pulse;

  // typed-in answer, travelling alongside the payload it belongs to
  logic          known_valid  = 1'b0;
  timer_result_t known_result = '0;

  // predicted timer state
  logic [PRESCALE_W-1:0] prescale;
  logic [DATA_W-1:0]     tmr_count   [NUM_TIMERS];
  logic [DATA_W-1:0]     tmr_reload  [NUM_TIMERS];
  logic [1:0]            tmr_div     [NUM_TIMERS];
  logic                  tmr_cascade [NUM_TIMERS];
  logic                  tmr_irq_en  [NUM_TIMERS];
  logic                  tmr_run     [NUM_TIMERS];

  timer_result_t pending_results [$];
  int            error_count = 0;
  int            sent_count  = 0;
  int            cycle_count = 0;
  bit            quiet_tail  = 1'b0;

  cascaded_timer_bank i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .irq_pulse  (irq_pulse)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one transaction to the predicted state and return its result
  function automatic timer_result_t advance_timers(input logic [1:0] act,
                                                   input logic [OFFSET_W-1:0] off,
                                                   input logic [DATA_W-1:0] data);
    timer_result_t res;
    int            t;
    int            n;
    int            shift;
    bit            carry_in;
    bit            counts;
    bit            wrapped;
    res = '0;
    t   = int'(off >> 1);
    case (act)
      ACT_TICK: begin
        prescale = prescale + 1'b1;
        // timer 0 sees no carry, so in cascade mode it stands still
        carry_in = 1'b0;
        for (n = 0; n < NUM_TIMERS; n++) begin
          counts  = 1'b0;
          wrapped = 1'b0;
          if (tmr_run[n]) begin
            if (tmr_cascade[n]) begin
              counts = carry_in;
            end else begin
              shift  = (tmr_div[n] == DIV_1) ? 0 : 4 + 2 * int'(tmr_div[n]);
              counts = (int'(prescale) & ((1 << shift) - 1)) == 0;
            end
          end
          if (counts) begin
            if (tmr_count[n] == '1) begin
              wrapped      = 1'b1;
              tmr_count[n] = tmr_reload[n];
              if (tmr_irq_en[n] && n < IRQ_W) res.irq_pulse[n] = 1'b1;
            end else begin
              tmr_count[n] = tmr_count[n] + 1'b1;
            end
          end
          carry_in = wrapped;
        end
      end
      ACT_READ: begin
        if (t < NUM_TIMERS) begin
          if (off[0]) begin
            res.read_data[CTL_DIV_LSB +: 2] = tmr_div[t];
            res.read_data[CTL_CASCADE]      = tmr_cascade[t];
            res.read_data[CTL_IRQ]          = tmr_irq_en[t];
            res.read_data[CTL_ENABLE]       = tmr_run[t];
          end else begin
            res.read_data = tmr_count[t];
          end
        end
      end
      ACT_WRITE: begin
        if (t < NUM_TIMERS) begin
          if (off[0]) begin
            // load the count only on a stopped-to-running change
            if (!tmr_run[t] && data[CTL_ENABLE]) tmr_count[t] = tmr_reload[t];
            tmr_div[t]     = data[CTL_DIV_LSB +: 2];
            tmr_cascade[t] = data[CTL_CASCADE];
            tmr_irq_en[t]  = data[CTL_IRQ];
            tmr_run[t]     = data[CTL_ENABLE];
          end else begin
            tmr_reload[t] = data;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Check results against the oldest expectation, then predict accepted transactions
  always @(posedge clk) begin
    timer_result_t want;
    int            n;
    if (rst) begin
      prescale = '0;
      for (n = 0; n < NUM_TIMERS; n++) begin
        tmr_count[n]   = '0;
        tmr_reload[n]  = '0;
        tmr_div[n]     = DIV_1;
        tmr_cascade[n] = 1'b0;
        tmr_irq_en[n]  = 1'b0;
        tmr_run[n]     = 1'b0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no transaction pending: read_data %h, irq_pulse %h",
                 read_data, irq_pulse);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data mismatch: expected %h, actual %h", want.read_data, read_data);
            error_count++;
          end
          if (irq_pulse !== want.irq_pulse) begin
            $error("irq_pulse mismatch: expected %h, actual %h", want.irq_pulse, irq_pulse);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = advance_timers(action, reg_offset, write_data);
        if (known_valid) want = known_result;
        pending_results.push_back(want);
      end
    end
  end

  // Stop a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side in random bursts, with calm stretches between
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!quiet_tail && ((cycle_count / 300) % 4 != 3) && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction, with an optional idle burst ahead of it, and hold it until taken
  task automatic send_transaction(input logic [1:0] act, input logic [OFFSET_W-1:0] off,
                                  input logic [DATA_W-1:0] data, input logic known,
                                  input timer_result_t res);
    int gap;
    gap = 0;
    if (!quiet_tail && ((sent_count / 160) % 3 != 2) && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    reg_offset   <= off;
    write_data   <= data;
    known_valid  <= known;
    known_result <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (sent_count >= ITEM_TARGET - QUIET_ITEMS) quiet_tail = 1'b1;
  endtask

  initial begin
    int                  i;
    int                  sel;
    int                  pick;
    logic [1:0]          act;
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]   data;
    logic [DATA_W-1:0]   ctl;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    for (i = 0; i < NUM_ROWS; i++)
      send_transaction(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].off, DIRECTED_ROWS[i].data,
                       DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);

    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 11) == 0) begin
        // arm one timer close to its wrap point, then let it run
        sel = $urandom_range(0, NUM_TIMERS - 1);
        ctl = DATA_W'($urandom);
        ctl[CTL_ENABLE] = 1'b0;
        send_transaction(ACT_WRITE, OFFSET_W'(2 * sel + 1), ctl, 1'b0, '0);
        send_transaction(ACT_WRITE, OFFSET_W'(2 * sel),
                         16'hFFFF - DATA_W'($urandom_range(0, 40)), 1'b0, '0);
        ctl = DATA_W'($urandom);
        ctl[CTL_ENABLE] = 1'b1;
        ctl[CTL_DIV_LSB +: 2] = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : DIV_1;
        ctl[CTL_CASCADE] = (sel > 0) && ($urandom_range(0, 1) == 1);
        send_transaction(ACT_WRITE, OFFSET_W'(2 * sel + 1), ctl, 1'b0, '0);
        repeat ($urandom_range(10, 60)) begin
          if ($urandom_range(0, 9) < 7)
            send_transaction(ACT_TICK, OFFSET_W'($urandom_range(0, 7)),
                             DATA_W'($urandom), 1'b0, '0);
          else
            send_transaction(ACT_READ, OFFSET_W'($urandom_range(0, 7)),
                             DATA_W'($urandom), 1'b0, '0);
        end
      end else begin
        // loose transactions of every kind
        pick = $urandom_range(0, 99);
        off  = OFFSET_W'($urandom_range(0, 7));
        data = DATA_W'($urandom);
        if (pick < 50)      act = ACT_TICK;
        else if (pick < 75) act = ACT_READ;
        else if (pick < 97) act = ACT_WRITE;
        else                act = ACT_UNUSED;
        if (act == ACT_WRITE && $urandom_range(0, 1) == 1) begin
          if (off[0]) data[CTL_DIV_LSB +: 2] = DIV_1;
          else        data = 16'hFFFF - DATA_W'($urandom_range(0, 200));
        end
        send_transaction(act, off, data, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain, then idle for DRAIN_CYCLES to catch anything stray
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ctb_pkg.sv
design/ctb_timer.sv
design/cascaded_timer_bank.sv
test/cascaded_timer_bank_tb.sv
